// ----- rtl/cnlv_pkg.sv -----
// Shared constants and types of the Luhn card number validator.
package cnlv_pkg;

    localparam int MAX_DIGITS  = 31;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int DIGIT_W     = 4;
    localparam int LEN_W       = 5;
    localparam int TOTAL_W     = 5;
    localparam int LEAD_W      = 10;
    localparam int SUM_W       = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RESET = 5'd13;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 5'd16;

    // Register index, taken from paddr[2].
    localparam logic REG_MIN_LENGTH = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    // Totals collected at the end of one card number.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              overflow;
        logic              prefix_ok;
        logic [LEAD_W-1:0] leading;
        logic [SUM_W-1:0]  plain_sum;
        logic [SUM_W-1:0]  doubled_sum;
    } snap_t;

endpackage

// ----- rtl/cnlv_accum.sv -----
// Digit input register, running Luhn accumulators and end-of-number snapshot register.
module cnlv_accum (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cnlv_pkg::DIGIT_W-1:0] in_digit,
    input  logic                         in_last,
    output logic                         snap_valid,
    output cnlv_pkg::snap_t              snap,
    input  logic                         snap_ready
);
    import cnlv_pkg::*;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 4'd9;
    localparam logic [DIGIT_W-1:0] PREFIX_FOUR   = 4'd4;
    localparam logic [DIGIT_W-1:0] PREFIX_FIVE   = 4'd5;
    localparam logic [DIGIT_W-1:0] PREFIX_SIX    = 4'd6;
    localparam logic [DIGIT_W-1:0] PAIR_HIGH     = 4'd3;
    localparam logic [DIGIT_W-1:0] PAIR_LOW      = 4'd7;
    localparam logic [CNT_W-1:0]   LEAD_DIGITS   = CNT_W'(3);
    localparam logic [CNT_W-1:0]   COUNT_LIMIT   = CNT_W'(MAX_DIGITS);

    // Doubling with digit-sum folding: 2d above 9 becomes 2d - 9.
    function automatic logic [DIGIT_W-1:0] fold_double(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W:0] t;
        t = {d, 1'b0};
        return (t > 5'd9) ? DIGIT_W'(t - 5'd9) : DIGIT_W'(t);
    endfunction

    logic                 in_valid_reg;
    logic [DIGIT_W-1:0]   in_digit_reg;
    logic                 in_last_reg;
    logic                 advance;

    logic [CNT_W-1:0]     cnt_reg,  cnt_next;
    logic                 ovf_reg,  ovf_next;
    logic [LEAD_W-1:0]    lead_reg, lead_next;
    logic [DIGIT_W-1:0]   first_reg, first_next;
    logic                 pair37_reg, pair37_next;
    logic [SUM_W-1:0]     plain_even_reg, plain_even_next;
    logic [SUM_W-1:0]     plain_odd_reg,  plain_odd_next;
    logic [SUM_W-1:0]     dbl_even_reg,   dbl_even_next;
    logic [SUM_W-1:0]     dbl_odd_reg,    dbl_odd_next;
    logic [DIGIT_W-1:0]   folded;

    logic                 snap_valid_reg;
    snap_t                snap_reg, snap_next;

    // A final digit may only leave the input register when the snapshot can take it.
    assign advance  = in_valid_reg && (!in_last_reg || !snap_valid_reg || snap_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Digits above nine are taken as nine.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_digit_reg <= (in_digit > DIGIT_MAX) ? DIGIT_MAX : in_digit;
            in_last_reg  <= in_last;
        end
    end

    assign folded = fold_double(in_digit_reg);

    always_comb
    begin
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        lead_next       = lead_reg;
        first_next      = first_reg;
        pair37_next     = pair37_reg;
        plain_even_next = plain_even_reg;
        plain_odd_next  = plain_odd_reg;
        dbl_even_next   = dbl_even_reg;
        dbl_odd_next    = dbl_odd_reg;
        if (cnt_reg < COUNT_LIMIT)
        begin
            if (!cnt_reg[0])
            begin
                plain_even_next = plain_even_reg + SUM_W'(in_digit_reg);
                dbl_even_next   = dbl_even_reg + SUM_W'(folded);
            end
            else
            begin
                plain_odd_next = plain_odd_reg + SUM_W'(in_digit_reg);
                dbl_odd_next   = dbl_odd_reg + SUM_W'(folded);
            end
            if (cnt_reg < LEAD_DIGITS)
            begin
                lead_next = LEAD_W'({lead_reg, 3'b000}) + LEAD_W'({lead_reg, 1'b0})
                          + LEAD_W'(in_digit_reg);
            end
            if (cnt_reg == '0)
            begin
                first_next = in_digit_reg;
            end
            if (cnt_reg == CNT_W'(1))
            begin
                pair37_next = (first_reg == PAIR_HIGH) && (in_digit_reg == PAIR_LOW);
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // The rightmost digit decides which parity holds the plain and the doubled places.
    always_comb
    begin
        snap_next.count     = cnt_next;
        snap_next.overflow  = ovf_next;
        snap_next.leading   = lead_next;
        snap_next.prefix_ok = (first_next == PREFIX_FOUR) || (first_next == PREFIX_FIVE)
                            || (first_next == PREFIX_SIX) || pair37_next;
        if (cnt_next[0])
        begin
            snap_next.plain_sum   = plain_even_next;
            snap_next.doubled_sum = dbl_odd_next;
        end
        else
        begin
            snap_next.plain_sum   = plain_odd_next;
            snap_next.doubled_sum = dbl_even_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            lead_reg       <= '0;
            first_reg      <= '0;
            pair37_reg     <= 1'b0;
            plain_even_reg <= '0;
            plain_odd_reg  <= '0;
            dbl_even_reg   <= '0;
            dbl_odd_reg    <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                cnt_reg        <= '0;
                ovf_reg        <= 1'b0;
                lead_reg       <= '0;
                first_reg      <= '0;
                pair37_reg     <= 1'b0;
                plain_even_reg <= '0;
                plain_odd_reg  <= '0;
                dbl_even_reg   <= '0;
                dbl_odd_reg    <= '0;
            end
            else
            begin
                cnt_reg        <= cnt_next;
                ovf_reg        <= ovf_next;
                lead_reg       <= lead_next;
                first_reg      <= first_next;
                pair37_reg     <= pair37_next;
                plain_even_reg <= plain_even_next;
                plain_odd_reg  <= plain_odd_next;
                dbl_even_reg   <= dbl_even_next;
                dbl_odd_reg    <= dbl_odd_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ----- rtl/card_number_luhn_validator.sv -----
// Top level of the streaming Luhn card number validator with its configuration registers.
//
// Digits of a card number arrive on the s_axis channel, one transaction per decimal
// digit, most significant digit first; s_axis_tlast marks the final digit. Each
// transaction is registered, folded into running plain and doubled sums for both
// position parities, and counted. On the final digit a snapshot of the totals is
// taken and the verdict is computed into the output register, which drives the
// m_axis channel with one result transaction per card number.
// The final digit moves through the input, snapshot and output registers in turn.
// Throughput: one digit per cycle while s_axis_tready stays high, set by the single
// accumulator update per cycle; numbers may follow each other with no gap.
// When m_axis_tready is low the result holds; digits keep being accepted until the
// next final digit finds both the snapshot and output registers full, and only then
// s_axis_tready drops.
// Reset clears the running sums and counts and sets min_length to 13 and max_length to 16.
// The APB port writes min_length at address 0 and max_length at address 4; the user
// must write them only while no number is in progress, which the block does not enforce.
module card_number_luhn_validator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cnlv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [3:0] digit
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] card_valid, [1] length_ok, [2] prefix_ok, [3] checksum_ok, [8:4] digit_total,
    // [18:9] leading_three, [27:19] doubled_place_sum, [36:28] plain_place_sum
    output logic [cnlv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cnlv_pkg::PADDR_W-1:0]     paddr,
    input  logic [cnlv_pkg::PDATA_W-1:0]     pwdata,
    output logic [cnlv_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import cnlv_pkg::*;

    // x / 10 equals (x * 205) >> 11 for every x below 1029.
    localparam int RECIP_W     = 8;
    localparam int RECIP_SHIFT = 11;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 8'd205;
    localparam int TOTAL_SUM_W = SUM_W + 1;
    localparam int PROD_W      = TOTAL_SUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    logic [LEN_W-1:0]       min_length_reg;
    logic [LEN_W-1:0]       max_length_reg;
    logic                   cfg_write;
    logic                   reg_index;

    logic                   snap_valid;
    logic                   snap_ready;
    snap_t                  snap;

    logic                   length_ok;
    logic                   checksum_ok;
    logic [TOTAL_SUM_W-1:0] place_total;
    logic [PROD_W-1:0]      recip_prod;
    logic [QUOT_W-1:0]      tens;
    logic [TOTAL_SUM_W-1:0] tens_times_ten;
    logic [OUT_TDATA_W-1:0] result_next;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_MIN_LENGTH: min_length_reg <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH: max_length_reg <= pwdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_MIN_LENGTH: prdata = PDATA_W'(min_length_reg);
            REG_MAX_LENGTH: prdata = PDATA_W'(max_length_reg);
            default:        prdata = '0;
        endcase
    end

    cnlv_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_digit   (s_axis_tdata[DIGIT_W-1:0]),
        .in_last    (s_axis_tlast),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    // Verdict on the snapshot
    assign length_ok = !snap.overflow
                     && (snap.count >= CNT_W'(min_length_reg))
                     && (snap.count <= CNT_W'(max_length_reg));

    assign place_total    = TOTAL_SUM_W'(snap.plain_sum) + TOTAL_SUM_W'(snap.doubled_sum);
    assign recip_prod     = PROD_W'(place_total) * PROD_W'(RECIP_TEN);
    assign tens           = recip_prod[PROD_W-1:RECIP_SHIFT];
    assign tens_times_ten = TOTAL_SUM_W'({tens, 3'b000}) + TOTAL_SUM_W'({tens, 1'b0});
    assign checksum_ok    = (place_total == tens_times_ten);

    assign result_next = {
        {(OUT_TDATA_W - 4 - TOTAL_W - LEAD_W - 2 * SUM_W){1'b0}},
        snap.plain_sum,
        snap.doubled_sum,
        snap.leading,
        snap.count[TOTAL_W-1:0],
        checksum_ok,
        snap.prefix_ok,
        length_ok,
        length_ok && snap.prefix_ok && checksum_ok
    };

    // Output register
    assign snap_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            m_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            m_data_reg <= result_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A snapshot that cannot drain must not be overwritten by the next number.
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid && !snap_ready |=> snap_valid && $stable(snap))
        else $error("snapshot changed while stalled");

    // The digit count saturates, and an overflow only happens at the limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid |-> (snap.count <= CNT_W'(MAX_DIGITS))
                    && (!snap.overflow || (snap.count == CNT_W'(MAX_DIGITS))))
        else $error("digit count beyond limit");

    // A passing length lies within the configured range.
    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |->
            (m_axis_tdata[8:4] >= min_length_reg) && (m_axis_tdata[8:4] <= max_length_reg))
        else $error("length flag outside configured range");

endmodule
